// File: sv/bcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the block claim checker: field widths,
// request operation codes, register indexes and the decoded area record.
// ----------------------------------------------------------------------------
package bcc_pkg;

   // fixed field widths
   localparam int ADDR_W       = 24;  // data area registers
   localparam int OP_W         = 2;
   localparam int SLOT_W       = 6;
   localparam int DUP_W        = 18;
   localparam int MAP_W        = 8;   // bits per bitmap byte
   localparam int AREA_BYTES_W = 22;  // ceil(2^24 / 8) needs 22 bits
   localparam int CSR_AW       = 4;
   localparam int CSR_DW       = 32;
   localparam int RSP_W        = 40;  // 39 bits of fields, padded to bytes

   // counter limits
   localparam logic [DUP_W-1:0] DUP_MAX  = 18'd131072;
   localparam logic [DUP_W-1:0] MISS_MAX = 18'h3ffff;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_CLAIM = 2'd0,
      OP_WATCH = 2'd1,
      OP_COUNT = 2'd2,
      OP_CLEAR = 2'd3
   } op_type;

   // register indexes (word address)
   typedef enum logic [1:0] {
      REG_START  = 2'd0,
      REG_LIMIT  = 2'd1,
      REG_ENABLE = 2'd2
   } reg_index_type;

   // decoded data area, derived from the registers
   typedef struct packed {
      logic [ADDR_W-1:0]       area_start;
      logic [ADDR_W-1:0]       area_limit;
      logic [ADDR_W-1:0]       area_len;
      logic [AREA_BYTES_W-1:0] area_bytes;
      logic                    tracking;
   } area_type;

endpackage
`default_nettype wire

// File: sv/block_claim_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// block_claim_checker
// Checks claimed block numbers against the data area, a claimed-block
// bitmap and a watch list; counts duplicates and unclaimed blocks.
//
//   channel  dir  handshake               payload
//   req_     in   tvalid/tready           tdata: operation, block_number,
//                                                watch_slot
//   rsp_     out  tvalid/tready           tdata: out_of_range, duplicate,
//                                                watched, dup_total,
//                                                missing_total
//   csr_     in   psel/penable/pready     paddr, pwdata, prdata
//
// One request at a time under a small sequencer; the bitmap port and the
// watch-list read port are the shared resources stepped through per request.
// Claim in range: range check, bitmap read-modify-write when tracking is on,
// then each watch slot read and compared in turn, then the response.
// Out of range or watch write: range check or slot write, then the response.
// Count: each bitmap byte of the area read and then counted; straight to the
// response when tracking is off or the area is empty.
// Clear: a clearing pass over every bitmap byte; after reset a clearing pass
// runs before the first request is taken (configuration writes still work).
// A new request is taken while a finished response waits on rsp_tready.
// ----------------------------------------------------------------------------
module block_claim_checker
   import bcc_pkg::*;
#(
   parameter int MAP_BYTES   = 16384,
   parameter int WATCH_SLOTS = 40,
   parameter int BLOCK_BITS  = 24
) (
   input  wire logic              clock,
   input  wire logic              reset,
   // request channel
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   // [1:0] operation, [BLOCK_BITS+1:2] block_number, next 6 bits watch_slot
   input  wire logic [((OP_W + BLOCK_BITS + SLOT_W + 7) / 8) * 8 - 1:0] req_tdata,
   // response channel
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   // [0] out_of_range, [1] duplicate, [2] watched, [20:3] dup_total,
   // [38:21] missing_total
   output logic      [RSP_W-1:0]  rsp_tdata,
   // configuration port
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int MAP_AW   = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
   localparam int WATCH_IW = (WATCH_SLOTS > 1) ? $clog2(WATCH_SLOTS) : 1;
   localparam int CMP_W    = (BLOCK_BITS > ADDR_W) ? BLOCK_BITS : ADDR_W;
   localparam logic [MAP_AW-1:0]   MAP_LAST   = MAP_AW'(MAP_BYTES - 1);
   localparam logic [WATCH_IW-1:0] WATCH_LAST = WATCH_IW'(WATCH_SLOTS - 1);
   localparam logic [SLOT_W:0]     SLOT_LIMIT = (SLOT_W + 1)'(WATCH_SLOTS);

   typedef enum logic [10:0] {
      S_WIPE  = 11'b000_0000_0001,
      S_IDLE  = 11'b000_0000_0010,
      S_RANGE = 11'b000_0000_0100,
      S_MAPRD = 11'b000_0000_1000,
      S_MAPWR = 11'b000_0001_0000,
      S_WRD   = 11'b000_0010_0000,
      S_WCMP  = 11'b000_0100_0000,
      S_SLOT  = 11'b000_1000_0000,
      S_MRD   = 11'b001_0000_0000,
      S_MCNT  = 11'b010_0000_0000,
      S_DONE  = 11'b100_0000_0000
   } state_type;

   function automatic logic [3:0] count_ones(input logic [MAP_W-1:0] value);
      logic [3:0] total;
      total = '0;
      for (int i = 0; i < MAP_W; i++) begin
         total = total + 4'(value[i]);
      end
      return total;
   endfunction

   area_type area;

   state_type state_ff, state_in;
   logic [BLOCK_BITS-1:0] bno_ff, bno_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [ADDR_W-1:0] d_ff, d_in;
   logic [MAP_AW-1:0] mcnt_ff, mcnt_in;
   logic [WATCH_IW-1:0] wcnt_ff, wcnt_in;
   logic oor_ff, oor_in;
   logic dup_ff, dup_in;
   logic wat_ff, wat_in;
   logic [DUP_W-1:0] miss_ff, miss_in;
   logic [DUP_W-1:0] dup_cnt_ff, dup_cnt_in;
   logic wipe_resp_ff, wipe_resp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff, rsp_data_in;

   op_type req_op;
   logic [BLOCK_BITS-1:0] req_bno;
   logic [SLOT_W-1:0] req_slot;

   logic map_we;
   logic [MAP_AW-1:0] map_waddr, map_raddr;
   logic [MAP_W-1:0] map_wdata, map_rdata;
   logic watch_we;
   logic [WATCH_IW-1:0] watch_raddr;
   logic [BLOCK_BITS-1:0] watch_rdata;
   logic watch_rvalid;

   logic [MAP_AW-1:0] byte_sel;
   logic [MAP_AW-1:0] last_byte;
   logic [MAP_W-1:0] bit_mask;
   logic [MAP_W-1:0] tail_mask;
   logic [DUP_W:0] miss_sum;

   // configuration registers
   bcc_csr #(
      .MAP_BYTES (MAP_BYTES)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .area        (area)
   );

   // claimed-block bitmap
   bcc_map_ram #(
      .DEPTH (MAP_BYTES),
      .AW    (MAP_AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   // watch list
   bcc_watch_list #(
      .SLOTS (WATCH_SLOTS),
      .IW    (WATCH_IW),
      .BW    (BLOCK_BITS)
   ) u_watch (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (watch_we),
      .wr_addr  (slot_ff[WATCH_IW-1:0]),
      .wr_data  (bno_ff),
      .rd_addr  (watch_raddr),
      .rd_data  (watch_rdata),
      .rd_valid (watch_rvalid)
   );

   // request fields
   assign req_op   = op_type'(req_tdata[OP_W-1:0]);
   assign req_bno  = req_tdata[OP_W +: BLOCK_BITS];
   assign req_slot = req_tdata[OP_W + BLOCK_BITS +: SLOT_W];

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // bitmap byte and bit of the current claim, last byte of the area
   assign byte_sel  = d_ff[MAP_AW+2:3];
   assign bit_mask  = MAP_W'(1) << d_ff[2:0];
   assign last_byte = MAP_AW'(area.area_bytes - AREA_BYTES_W'(1));
   assign tail_mask = ((mcnt_ff == last_byte) && (area.area_len[2:0] != 3'd0)) ?
                      ~(8'hff << area.area_len[2:0]) : 8'hff;
   assign miss_sum  = {1'b0, miss_ff} +
                      (DUP_W + 1)'(count_ones(~map_rdata & tail_mask));

   // sequencer
   always_comb begin
      state_in     = state_ff;
      bno_in       = bno_ff;
      slot_in      = slot_ff;
      d_in         = d_ff;
      mcnt_in      = mcnt_ff;
      wcnt_in      = wcnt_ff;
      oor_in       = oor_ff;
      dup_in       = dup_ff;
      wat_in       = wat_ff;
      miss_in      = miss_ff;
      dup_cnt_in   = dup_cnt_ff;
      wipe_resp_in = wipe_resp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      map_we       = 1'b0;
      map_waddr    = byte_sel;
      map_wdata    = map_rdata | bit_mask;
      map_raddr    = byte_sel;
      watch_we     = 1'b0;
      watch_raddr  = wcnt_ff;

      unique case (state_ff)
         // clearing pass, one byte a cycle
         S_WIPE: begin
            map_we    = 1'b1;
            map_waddr = mcnt_ff;
            map_wdata = '0;
            mcnt_in   = mcnt_ff + MAP_AW'(1);
            if (mcnt_ff == MAP_LAST) begin
               mcnt_in  = '0;
               state_in = wipe_resp_ff ? S_DONE : S_IDLE;
            end
         end

         // take a request
         S_IDLE: begin
            if (req_tvalid) begin
               bno_in  = req_bno;
               slot_in = req_slot;
               oor_in  = 1'b0;
               dup_in  = 1'b0;
               wat_in  = 1'b0;
               miss_in = '0;
               mcnt_in = '0;
               wcnt_in = '0;
               unique case (req_op)
                  OP_CLAIM: state_in = S_RANGE;
                  OP_WATCH: state_in = S_SLOT;
                  OP_COUNT: state_in = S_MRD;
                  OP_CLEAR: begin
                     dup_cnt_in   = '0;
                     wipe_resp_in = 1'b1;
                     state_in     = S_WIPE;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end

         // range check and offset into the area
         S_RANGE: begin
            d_in = ADDR_W'(CMP_W'(bno_ff) - CMP_W'(area.area_start));
            if ((CMP_W'(bno_ff) < CMP_W'(area.area_start)) ||
                (CMP_W'(bno_ff) >= CMP_W'(area.area_limit))) begin
               oor_in   = 1'b1;
               state_in = S_DONE;
            end else if (area.tracking) begin
               state_in = S_MAPRD;
            end else begin
               state_in = S_WRD;
            end
         end

         // bitmap read-modify-write
         S_MAPRD: begin
            state_in = S_MAPWR;
         end

         S_MAPWR: begin
            if ((map_rdata & bit_mask) != '0) begin
               dup_in = 1'b1;
               if (dup_cnt_ff < DUP_MAX) begin
                  dup_cnt_in = dup_cnt_ff + DUP_W'(1);
               end
            end else begin
               map_we = 1'b1;
            end
            state_in = S_WRD;
         end

         // watch list scan, each slot read and then compared
         S_WRD: begin
            state_in = S_WCMP;
         end

         S_WCMP: begin
            if (watch_rvalid && (watch_rdata == bno_ff)) begin
               wat_in = 1'b1;
            end
            if (wcnt_ff == WATCH_LAST) begin
               state_in = S_DONE;
            end else begin
               wcnt_in  = wcnt_ff + WATCH_IW'(1);
               state_in = S_WRD;
            end
         end

         // watch entry write, slots past the list are dropped
         S_SLOT: begin
            watch_we = ({1'b0, slot_ff} < SLOT_LIMIT);
            state_in = S_DONE;
         end

         // unclaimed count, each bitmap byte read and then counted
         S_MRD: begin
            map_raddr = mcnt_ff;
            if (!area.tracking || (area.area_len == '0)) begin
               state_in = S_DONE;
            end else begin
               state_in = S_MCNT;
            end
         end

         S_MCNT: begin
            miss_in = (miss_sum > (DUP_W + 1)'(MISS_MAX)) ? MISS_MAX :
                      miss_sum[DUP_W-1:0];
            if (mcnt_ff == last_byte) begin
               state_in = S_DONE;
            end else begin
               mcnt_in  = mcnt_ff + MAP_AW'(1);
               state_in = S_MRD;
            end
         end

         // hand over the response once the output register is free
         S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, miss_ff, dup_cnt_ff, wat_ff, dup_ff, oor_ff};
               wipe_resp_in = 1'b0;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_WIPE;
         mcnt_ff      <= '0;
         dup_cnt_ff   <= '0;
         wipe_resp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mcnt_ff      <= mcnt_in;
         dup_cnt_ff   <= dup_cnt_in;
         wipe_resp_ff <= wipe_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      bno_ff      <= bno_in;
      slot_ff     <= slot_in;
      d_ff        <= d_in;
      wcnt_ff     <= wcnt_in;
      oor_ff      <= oor_in;
      dup_ff      <= dup_in;
      wat_ff      <= wat_in;
      miss_ff     <= miss_in;
      rsp_data_ff <= rsp_data_in;
   end

   // assertions
   a_oor_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[0]) |-> (!rsp_data_ff[1] && !rsp_data_ff[2]))
      else $error("out-of-range response flags duplicate or watched");

   a_wipe_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WIPE) |-> !req_tready)
      else $error("request taken during clearing pass");

   a_dup_cap: assert property (@(posedge clock) disable iff (reset)
      dup_cnt_ff <= DUP_MAX)
      else $error("duplicate counter past its limit");

   a_dup_step: assert property (@(posedge clock) disable iff (reset)
      (dup_cnt_ff != $past(dup_cnt_ff)) |->
         ((dup_cnt_ff == $past(dup_cnt_ff) + DUP_W'(1)) || (dup_cnt_ff == '0)))
      else $error("duplicate counter jumped");

endmodule
`default_nettype wire

// File: sv/bcc_map_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_map_ram
// Claimed-block bitmap storage: one write port and one read port,
// one byte per entry, registered read data.
// ----------------------------------------------------------------------------
module bcc_map_ram
   import bcc_pkg::*;
#(
   parameter int DEPTH = 16384,
   parameter int AW    = 14
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [MAP_W-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [MAP_W-1:0] rd_data
);

   logic [MAP_W-1:0] mem_ff [DEPTH];
   logic [MAP_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: sv/bcc_watch_list.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_watch_list
// Watch address storage with per-slot valid flags. Writing address zero
// invalidates a slot. One slot is read per cycle, data and flag registered.
// ----------------------------------------------------------------------------
module bcc_watch_list
   import bcc_pkg::*;
#(
   parameter int SLOTS = 40,
   parameter int IW    = 6,
   parameter int BW    = 24
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          wr_en,
   input  wire logic [IW-1:0] wr_addr,
   input  wire logic [BW-1:0] wr_data,
   input  wire logic [IW-1:0] rd_addr,
   output logic      [BW-1:0] rd_data,
   output logic               rd_valid
);

   logic [BW-1:0] watch_mem_ff [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic [BW-1:0] rd_data_ff;
   logic rd_valid_ff;

   // address storage
   always_ff @(posedge clock) begin
      if (wr_en) begin
         watch_mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= watch_mem_ff[rd_addr];
   end

   // valid flags, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= (wr_data != '0);
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data  = rd_data_ff;
   assign rd_valid = rd_valid_ff;

endmodule
`default_nettype wire

// File: sv/bcc_csr.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_csr
// Configuration registers behind the APB-style port, plus the decoded data
// area (length, byte count, tracking enable) registered for the sequencer.
// ----------------------------------------------------------------------------
module bcc_csr
   import bcc_pkg::*;
#(
   parameter int MAP_BYTES = 16384
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready,
   output area_type               area
);

   localparam logic [AREA_BYTES_W-1:0] MAP_BYTES_L = AREA_BYTES_W'(MAP_BYTES);

   logic [ADDR_W-1:0] start_ff;
   logic [ADDR_W-1:0] limit_ff;
   logic enable_ff;
   area_type area_ff;
   area_type area_in;
   reg_index_type index;
   logic wr_hit;
   logic [ADDR_W:0] len_round;

   assign csr_pready = 1'b1;
   assign index      = reg_index_type'(csr_paddr[3:2]);
   assign wr_hit     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         limit_ff  <= '0;
         enable_ff <= 1'b1;
      end else if (wr_hit) begin
         unique case (index)
            REG_START:  start_ff  <= csr_pwdata[ADDR_W-1:0];
            REG_LIMIT:  limit_ff  <= csr_pwdata[ADDR_W-1:0];
            REG_ENABLE: enable_ff <= csr_pwdata[0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (index)
         REG_START:  csr_prdata = CSR_DW'(start_ff);
         REG_LIMIT:  csr_prdata = CSR_DW'(limit_ff);
         REG_ENABLE: csr_prdata = CSR_DW'(enable_ff);
         default:    csr_prdata = '0;
      endcase
   end

   // area decode: empty when limit <= start
   always_comb begin
      area_in.area_start = start_ff;
      area_in.area_limit = limit_ff;
      area_in.area_len   = (limit_ff > start_ff) ? (limit_ff - start_ff) : '0;
      len_round          = {1'b0, area_in.area_len} + (ADDR_W + 1)'(7);
      area_in.area_bytes = len_round[ADDR_W:3];
      area_in.tracking   = enable_ff && (area_in.area_bytes <= MAP_BYTES_L);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         area_ff <= '{area_start: '0, area_limit: '0, area_len: '0,
                      area_bytes: '0, tracking: 1'b1};
      end else begin
         area_ff <= area_in;
      end
   end

   assign area = area_ff;

endmodule
`default_nettype wire
